/* hdl/first_fit_segment_allocator_defines.svh */
// ----------------------------------------------------------------------------
// First-fit segment allocator assertion macros
// Concurrent check helpers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FFSA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define FFSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FFSA_ASSERT_IMPL(label, ante, cons, msg)
`define FFSA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* hdl/ffsa_pkg.sv */
// ----------------------------------------------------------------------------
// First-fit segment allocator package
// Field widths, command and status codes, and defaults.
// ----------------------------------------------------------------------------
package ffsa_pkg;

	localparam int unsigned SIZE_W   = 10;
	localparam int unsigned OWNER_W  = 8;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned POS_W    = 4;

	localparam int unsigned DEF_MAX_SEGMENTS = 16;

	localparam logic [SIZE_W-1:0]  TOTAL_RESET = 10'd10;
	localparam logic [OWNER_W-1:0] OWNER_FREE  = '0;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_BAD_REQ   = 3'd4;

endpackage

/* hdl/ffsa_if.sv */
// ----------------------------------------------------------------------------
// First-fit segment allocator channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffsa_req_if import ffsa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [OWNER_W-1:0] owner_id;
	logic [SIZE_W-1:0]  alloc_size;

	modport source (output valid, output cmd, output owner_id, output alloc_size, input ready);
	modport sink   (input valid, input cmd, input owner_id, input alloc_size, output ready);
endinterface

interface ffsa_rsp_if import ffsa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    segment_position;

	modport source (output valid, output status, output segment_position, input ready);
	modport sink   (input valid, input status, input segment_position, output ready);
endinterface

interface ffsa_cfg_if import ffsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] total_units;

	modport source (output valid, output total_units, input ready);
	modport sink   (input valid, input total_units, output ready);
endinterface

/* hdl/ffsa_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffsa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hdl/first_fit_segment_allocator.sv */
// Sequence (accept to rsp.valid): a bad request goes straight to ST_DONE; a free,
//   an exact fit or a split blocked by a full table ends at its hit, a miss scans
//   every entry, and a split moves the tail in ST_SHIFT, then runs ST_SPLIT, ST_CLAIM.
// Throughput: one item at a time; ready only while the sequencer is idle.
// Reset: async, active low; the init state writes entry 0 (total_units = 10),
//   then the block is ready. Entries past the segment count are never read.
// ----------------------------------------------------------------------------
// First-fit segment allocator
// Address-ordered segment table in RAM, scanned one entry per cycle by a
// small sequencer; an inexact allocation splits the hit segment and shifts the tail.
// ----------------------------------------------------------------------------
`include "first_fit_segment_allocator_defines.svh"

module first_fit_segment_allocator import ffsa_pkg::*; #(
	parameter int unsigned MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
	input  logic       clk,
	input  logic       arst_n,
	ffsa_req_if.sink   req,
	ffsa_rsp_if.source rsp,
	ffsa_cfg_if.sink   cfg
);

	localparam int unsigned AW      = $clog2(MAX_SEGMENTS);
	localparam int unsigned CW      = $clog2(MAX_SEGMENTS + 1);
	localparam int unsigned ENTRY_W = SIZE_W + OWNER_W;

	// one-hot sequencer
	typedef enum logic [6:0] {
		ST_INIT  = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_SCAN  = 7'b0000100,
		ST_SHIFT = 7'b0001000,
		ST_SPLIT = 7'b0010000,
		ST_CLAIM = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// control state
	logic [SIZE_W-1:0] total_q;
	logic [CW-1:0]     count_q;
	logic              scan_vld_s1;
	logic              shift_vld_s1;
	logic              out_valid_q;

	// request and datapath registers
	logic                cmd_q;
	logic [OWNER_W-1:0]  owner_q;
	logic [SIZE_W-1:0]   size_q;
	logic [CW-1:0]       idx_q;
	logic [AW-1:0]       scan_pos_s1;
	logic [AW-1:0]       hit_q;
	logic [SIZE_W-1:0]   rem_q;
	logic [AW-1:0]       src_q;
	logic [AW-1:0]       shift_addr_s1;
	logic [STATUS_W-1:0] res_status_q;
	logic [AW-1:0]       res_pos_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [POS_W-1:0]    out_pos_q;
	logic [POS_W-1:0]    pos_ext;

	// table RAM port
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	logic [SIZE_W-1:0]  rd_size;
	logic [OWNER_W-1:0] rd_owner;

	logic req_fire, bad_req, scan_issue, shift_issue;
	logic seg_take, seg_exact, table_full, scan_miss, out_free;

	ffsa_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_SEGMENTS)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_size  = rd_data[ENTRY_W-1:OWNER_W];
	assign rd_owner = rd_data[OWNER_W-1:0];

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign bad_req   = (req.owner_id == OWNER_FREE) ||
		((req.cmd == CMD_ALLOC) && (req.alloc_size == '0));

	assign rsp.valid            = out_valid_q;
	assign rsp.status           = out_status_q;
	assign rsp.segment_position = out_pos_q;
	assign out_free             = !out_valid_q || rsp.ready;

	// position reported modulo 16
	generate
		if (AW >= POS_W) begin : g_pos_trunc
			assign pos_ext = res_pos_q[POS_W-1:0];
		end else begin : g_pos_ext
			assign pos_ext = {{(POS_W - AW){1'b0}}, res_pos_q};
		end
	endgenerate

	// scan pipeline: entry checked in the cycle after its address is issued
	assign scan_issue  = (state_q == ST_SCAN) && (idx_q < count_q);
	assign shift_issue = (state_q == ST_SHIFT) && (src_q > hit_q);
	assign rd_en       = scan_issue || shift_issue;
	assign rd_addr     = (state_q == ST_SHIFT) ? src_q : idx_q[AW-1:0];

	// shared compare unit
	assign seg_exact  = (rd_size == size_q);
	assign seg_take   = (cmd_q == CMD_FREE) ? (rd_owner == owner_q) :
		((rd_owner == OWNER_FREE) && (rd_size >= size_q));
	assign table_full = (count_q == CW'(MAX_SEGMENTS));
	assign scan_miss  = !scan_vld_s1 && (idx_q == count_q);

	// table write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		priority if (cfg.valid) begin
			// total_units write: table back to one free segment
			wr_en   = 1'b1;
			wr_data = {cfg.total_units, OWNER_FREE};
		end else begin
			unique case (state_q)
				ST_INIT: begin
					wr_en   = 1'b1;
					wr_data = {total_q, OWNER_FREE};
				end
				ST_SCAN: begin
					// exact fit or free: rewrite owner in place
					if (scan_vld_s1 && seg_take && ((cmd_q == CMD_FREE) || seg_exact)) begin
						wr_en   = 1'b1;
						wr_addr = scan_pos_s1;
						wr_data = {rd_size, (cmd_q == CMD_FREE) ? OWNER_FREE : owner_q};
					end
				end
				ST_SHIFT: begin
					wr_en   = shift_vld_s1;
					wr_addr = shift_addr_s1;
					wr_data = rd_data;
				end
				ST_SPLIT: begin
					wr_en   = 1'b1;
					wr_addr = hit_q + 1'b1;
					wr_data = {rem_q, OWNER_FREE};
				end
				ST_CLAIM: begin
					wr_en   = 1'b1;
					wr_addr = hit_q;
					wr_data = {size_q, owner_q};
				end
				ST_IDLE, ST_DONE: begin
					wr_en = 1'b0;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: state_d = ST_IDLE;
			ST_IDLE: begin
				if (req_fire) begin
					state_d = bad_req ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				priority if (scan_vld_s1 && seg_take) begin
					if ((cmd_q == CMD_FREE) || seg_exact || table_full) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SHIFT;
					end
				end else if (scan_miss) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SHIFT: begin
				if (!shift_issue) begin
					state_d = ST_SPLIT;
				end
			end
			ST_SPLIT: state_d = ST_CLAIM;
			ST_CLAIM: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			total_q      <= TOTAL_RESET;
			count_q      <= CW'(1);
			scan_vld_s1  <= 1'b0;
			shift_vld_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			scan_vld_s1  <= scan_issue;
			shift_vld_s1 <= shift_issue;
			if (cfg.valid) begin
				total_q <= cfg.total_units;
				count_q <= CW'(1);
			end else if (state_q == ST_CLAIM) begin
				count_q <= count_q + 1'b1;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		scan_pos_s1   <= idx_q[AW-1:0];
		shift_addr_s1 <= src_q + 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					cmd_q        <= req.cmd;
					owner_q      <= req.owner_id;
					size_q       <= req.alloc_size;
					idx_q        <= '0;
					res_status_q <= STATUS_BAD_REQ;
					res_pos_q    <= '0;
				end
			end
			ST_SCAN: begin
				if (scan_issue) begin
					idx_q <= idx_q + 1'b1;
				end
				priority if (scan_vld_s1 && seg_take) begin
					hit_q <= scan_pos_s1;
					rem_q <= rd_size - size_q;
					src_q <= count_q[AW-1:0] - 1'b1;
					if ((cmd_q == CMD_ALLOC) && !seg_exact && table_full) begin
						res_status_q <= STATUS_FULL;
						res_pos_q    <= '0;
					end else begin
						res_status_q <= STATUS_OK;
						res_pos_q    <= scan_pos_s1;
					end
				end else if (scan_miss) begin
					res_status_q <= (cmd_q == CMD_FREE) ? STATUS_NOT_FOUND : STATUS_NO_FIT;
					res_pos_q    <= '0;
				end else begin
					res_pos_q <= res_pos_q;
				end
			end
			ST_SHIFT: begin
				if (shift_issue) begin
					src_q <= src_q - 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_pos_q    <= pos_ext;
				end
			end
			ST_INIT, ST_SPLIT, ST_CLAIM: begin
				src_q <= src_q;
			end
			default: begin
				src_q <= src_q;
			end
		endcase
	end

	// checks
	`FFSA_ASSERT_IMPL(a_count_range, 1'b1, (count_q != '0) && (count_q <= CW'(MAX_SEGMENTS)), "segment count out of range")
	`FFSA_ASSERT_NEXT(a_claim_grows, (state_q == ST_CLAIM) && !cfg.valid, count_q == $past(count_q) + 1'b1, "split did not grow the table")
	`FFSA_ASSERT_IMPL(a_rsp_from_done, $rose(out_valid_q), $past(state_q == ST_DONE), "response without finished request")
	`FFSA_ASSERT_IMPL(a_err_pos_zero, out_valid_q && (out_status_q != STATUS_OK), out_pos_q == '0, "error response with nonzero position")
	`FFSA_ASSERT_IMPL(a_shift_bound, state_q == ST_SHIFT, (src_q >= hit_q) && !table_full, "tail move past split point")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// First-fit segment allocator testbench
// Sends allocate and free items through the request channel and keeps a
// shadow segment table that predicts status and position for each item.
// Responses are checked in order. The table size is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import ffsa_pkg::*;

	localparam int unsigned SEGS        = DEF_MAX_SEGMENTS;
	localparam int unsigned SETTLE      = 2 * SEGS + 6;   // well above the worst item latency
	localparam int unsigned HOLDOFF     = 300;            // long response stall, in cycles
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_ITEMS = 115;
	localparam int unsigned OWNER_POOL  = 12;             // small pool so frees usually hit

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
	} seg_answer_t;

	// Shadow copy of the segment table. Each accepted item updates it and
	// queues the answer the block owes for that item.
	class segment_scoreboard;
		logic [SIZE_W-1:0]  total;
		logic [SIZE_W-1:0]  seg_size[SEGS];
		logic [OWNER_W-1:0] seg_owner[SEGS];
		int unsigned        seg_count;
		seg_answer_t        answers_q[$];
		int unsigned        mismatches;

		// any write of the total collapses the table to one free segment
		function void load_total(logic [SIZE_W-1:0] units);
			total = units;
			for (int i = 0; i < SEGS; i++) begin
				seg_size[i]  = '0;
				seg_owner[i] = OWNER_FREE;
			end
			seg_size[0] = units;
			seg_count   = 1;
		endfunction

		function new();
			mismatches = 0;
			load_total(TOTAL_RESET);
		endfunction

		function void note_request(logic cmd, logic [OWNER_W-1:0] owner,
				logic [SIZE_W-1:0] units);
			seg_answer_t ans;
			bit          done;
			ans.status   = STATUS_BAD_REQ;
			ans.position = '0;
			done         = 1'b0;
			if (owner == OWNER_FREE || (cmd == CMD_ALLOC && units == '0)) begin
				ans.status = STATUS_BAD_REQ;
			end else if (cmd == CMD_ALLOC) begin
				ans.status = STATUS_NO_FIT;
				for (int i = 0; i < seg_count && !done; i++) begin
					if (seg_owner[i] == OWNER_FREE && seg_size[i] >= units) begin
						// first fit decides; a blocked split does not look further
						done = 1'b1;
						if (seg_size[i] == units) begin
							seg_owner[i] = owner;
							ans.status   = STATUS_OK;
							ans.position = i[POS_W-1:0];
						end else if (seg_count >= SEGS) begin
							ans.status = STATUS_FULL;
						end else begin
							for (int j = int'(seg_count); j > i + 1; j--) begin
								seg_size[j]  = seg_size[j-1];
								seg_owner[j] = seg_owner[j-1];
							end
							seg_size[i+1]  = seg_size[i] - units;
							seg_owner[i+1] = OWNER_FREE;
							seg_size[i]    = units;
							seg_owner[i]   = owner;
							seg_count++;
							ans.status   = STATUS_OK;
							ans.position = i[POS_W-1:0];
						end
					end
				end
			end else begin
				ans.status = STATUS_NOT_FOUND;
				for (int i = 0; i < seg_count && !done; i++) begin
					if (seg_owner[i] == owner) begin
						done         = 1'b1;
						seg_owner[i] = OWNER_FREE;
						ans.status   = STATUS_OK;
						ans.position = i[POS_W-1:0];
					end
				end
			end
			answers_q.push_back(ans);
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_result(logic [STATUS_W-1:0] status, logic [POS_W-1:0] position);
			seg_answer_t ans;
			if (answers_q.size() == 0) begin
				report($sformatf("response with nothing pending: status %0d position %0d",
					status, position));
			end else begin
				ans = answers_q.pop_front();
				if (status !== ans.status)
					report($sformatf("status %0d, predicted %0d", status, ans.status));
				if (position !== ans.position)
					report($sformatf("position %0d, predicted %0d", position, ans.position));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	ffsa_req_if req_ch ();
	ffsa_rsp_if rsp_ch ();
	ffsa_cfg_if cfg_ch ();

	segment_scoreboard sb = new();

	bit          no_idle;      // last phase runs without idling on either side
	bit          holdoff_go;   // asks the response side for its one long stall
	int unsigned cycle_count = 0;

	first_fit_segment_allocator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a lost response or a hung handshake ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Response monitor. Sampled at the rising edge, before the block's own
	// updates for that edge land.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			sb.check_result(rsp_ch.status, rsp_ch.segment_position);
	end

	// Response ready: random stall bursts, plus one long hold-off counted here
	// while the request side keeps offering items.
	initial begin : rsp_ready_drive
		int unsigned stall_left;
		int unsigned holdoff_left;
		bit          holdoff_used;
		stall_left   = 0;
		holdoff_left = 0;
		holdoff_used = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_go && !holdoff_used) begin
				holdoff_used = 1'b1;
				holdoff_left = HOLDOFF;
			end
			if (holdoff_left != 0) begin
				holdoff_left--;
				rsp_ch.ready = 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = 1'b1;
				if (!no_idle && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 8);
			end
		end
	end

	function automatic logic [OWNER_W-1:0] OWNER_OWNER_CAST(int k);
		return k[OWNER_W-1:0];
	endfunction

	// One request item. Valid stays up from the accepting edge until the next
	// falling edge, where either the next item or an idle gap replaces it.
	task automatic send_request(logic cmd, logic [OWNER_W-1:0] owner,
			logic [SIZE_W-1:0] units);
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		req_ch.valid      = 1'b1;
		req_ch.cmd        = cmd;
		req_ch.owner_id   = owner;
		req_ch.alloc_size = units;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_request(cmd, owner, units);
	endtask

	// Total is only rewritten once every answer is in; every item answers,
	// so the block is idle by then.
	task automatic write_total(logic [SIZE_W-1:0] units);
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (sb.answers_q.size() != 0) @(negedge clk);
		cfg_ch.valid       = 1'b1;
		cfg_ch.total_units = units;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		sb.load_total(units);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Mostly well-formed alloc/free traffic from a small owner pool, so the
	// table fragments, fills and hits exact fits; some bad and out-of-range items.
	task automatic run_random(int unsigned count, bit with_holdoff);
		logic               cmd;
		logic [OWNER_W-1:0] owner;
		logic [SIZE_W-1:0]  units;
		int unsigned        roll;
		int unsigned        span;
		int                 nfree;
		int                 which;
		for (int unsigned k = 0; k < count; k++) begin
			if (with_holdoff && k == count / 3)
				holdoff_go = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 5)
				owner = OWNER_FREE;
			else if (roll < 85)
				owner = OWNER_W'($urandom_range(1, OWNER_POOL));
			else
				owner = OWNER_W'($urandom_range(1, 255));
			cmd  = ($urandom_range(0, 99) < 55) ? CMD_ALLOC : CMD_FREE;
			span = (sb.total == '0) ? 1 : 32'(sb.total);
			roll = $urandom_range(0, 99);
			if (cmd == CMD_FREE) begin
				units = SIZE_W'($urandom_range(0, 1023));  // don't-care for a free
			end else if (roll < 30) begin
				units = SIZE_W'($urandom_range(1, (span / 8 == 0) ? 1 : span / 8));
			end else if (roll < 55) begin
				units = SIZE_W'($urandom_range(1, span));
			end else if (roll < 75) begin
				// aim at an exact fit on one of the free segments
				units = SIZE_W'($urandom_range(1, span));
				nfree = 0;
				for (int i = 0; i < sb.seg_count; i++)
					if (sb.seg_owner[i] == OWNER_FREE) nfree++;
				if (nfree != 0) begin
					which = $urandom_range(0, nfree - 1);
					for (int i = 0; i < sb.seg_count; i++) begin
						if (sb.seg_owner[i] == OWNER_FREE) begin
							if (which == 0) units = sb.seg_size[i];
							which--;
						end
					end
				end
			end else if (roll < 92) begin
				units = SIZE_W'($urandom_range(1, 1023));
			end else begin
				units = SIZE_W'($urandom_range(0, 1023));
			end
			send_request(cmd, owner, units);
		end
	endtask

	initial begin : stimulus
		logic [SIZE_W-1:0] phase_total;
		arst_n             = 1'b0;
		no_idle            = 1'b0;
		holdoff_go         = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.cmd         = CMD_ALLOC;
		req_ch.owner_id    = OWNER_FREE;
		req_ch.alloc_size  = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.total_units = TOTAL_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: default total of 10 after reset
		send_request(CMD_ALLOC, OWNER_FREE, 10'd5);    // owner 0 rejected
		send_request(CMD_ALLOC, 8'd1, 10'd0);          // zero size rejected
		send_request(CMD_FREE, OWNER_FREE, 10'd0);     // owner 0 on free rejected
		send_request(CMD_FREE, 8'd7, 10'd3);           // nobody holds owner 7
		send_request(CMD_ALLOC, 8'd1, 10'd11);         // bigger than memory
		send_request(CMD_ALLOC, 8'd1, 10'd4);          // split of segment 0
		send_request(CMD_ALLOC, 8'd2, 10'd6);          // exact fit on the remainder
		send_request(CMD_FREE, 8'd1, 10'd1023);        // size field ignored on free
		send_request(CMD_ALLOC, 8'd255, 10'd1023);     // extreme fields, no fit

		// Fill the table with 1-unit splits until every slot is in use
		write_total(10'd1023);
		for (int k = 1; k < SEGS; k++)
			send_request(CMD_ALLOC, OWNER_OWNER_CAST(k), 10'd1);
		send_request(CMD_ALLOC, 8'd200, 10'd2);        // split blocked on full table
		send_request(CMD_ALLOC, 8'd255, 10'd1008);     // exact fit still works when full

		// Zero total leaves a zero-sized free segment nothing can take
		write_total(10'd0);
		send_request(CMD_ALLOC, 8'd9, 10'd1);
		write_total(10'd1);
		send_request(CMD_ALLOC, 8'd9, 10'd1);

		// Random phases over a spread of totals, extremes included
		for (int unsigned p = 0; p < PHASES; p++) begin
			case (p)
				0:       phase_total = 10'd1023;
				1:       phase_total = 10'd64;
				2:       phase_total = SIZE_W'($urandom_range(2, 1022));
				3:       phase_total = 10'd1;
				4:       phase_total = TOTAL_RESET;
				5:       phase_total = SIZE_W'($urandom_range(100, 400));
				6:       phase_total = SIZE_W'($urandom_range(2, 1022));
				default: phase_total = 10'd1023;
			endcase
			write_total(phase_total);
			no_idle = (p == PHASES - 1);
			run_random(PHASE_ITEMS, p == 2);
		end

		// Drain, then give stray responses time to show up
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (sb.answers_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
